### design/lbtc_pkg.sv
// ----------------------------------------------------------------------------
// lbtc_pkg
// shared types and constants for the laser blink / timeout controller
// ----------------------------------------------------------------------------
package lbtc_pkg;

    localparam int unsigned TIME_W         = 32;
    localparam int unsigned VALUE_W        = 32;
    localparam int unsigned LEVEL_W        = 8;
    localparam int unsigned DUTY_W         = 13;
    localparam int unsigned OP_W           = 2;
    localparam int unsigned PWM_FULL_SCALE = 8191;
    localparam int unsigned LEVEL_MAX      = 255;
    localparam int unsigned DUTY_STEP      = PWM_FULL_SCALE / LEVEL_MAX;

    typedef enum logic [OP_W-1:0] {
        OP_SET_LEVEL = 2'd0,
        OP_SET_BLINK = 2'd1,
        OP_TICK      = 2'd2,
        OP_NONE      = 2'd3
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [VALUE_W-1:0] value;
        logic [TIME_W-1:0]  now_ms;
    } cmd_t;

    typedef struct packed {
        logic [DUTY_W-1:0]  duty;
        logic               duty_written;
        logic               laser_on;
        logic [LEVEL_W-1:0] level_now;
    } result_t;

endpackage

### design/lbtc_in_stage.sv
// ----------------------------------------------------------------------------
// lbtc_in_stage
// input register holding one command until the core takes it
// ----------------------------------------------------------------------------
module lbtc_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  lbtc_pkg::cmd_t in_cmd,
    output logic           cmd_valid,
    input  logic           cmd_take,
    output lbtc_pkg::cmd_t cmd
);
    import lbtc_pkg::*;

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;

    // empty, or draining this cycle
    assign in_ready = !valid_reg || cmd_take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg <= in_cmd;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

### design/lbtc_core.sv
// ----------------------------------------------------------------------------
// lbtc_core
// controller state and the one-pass update for each command
// ----------------------------------------------------------------------------
module lbtc_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lbtc_pkg::TIME_W-1:0]      cfg_data,
    input  logic                             fire,
    input  lbtc_pkg::cmd_t                   cmd,
    output lbtc_pkg::result_t                result
);
    import lbtc_pkg::*;

    logic [TIME_W-1:0]  max_on_reg;
    logic [LEVEL_W-1:0] level_reg,     level_next;
    logic [LEVEL_W-1:0] blink_lvl_reg, blink_lvl_next;
    logic [TIME_W-1:0]  off_dl_reg,    off_dl_next;
    logic [TIME_W-1:0]  blink_dl_reg,  blink_dl_next;
    logic [TIME_W-1:0]  period_reg,    period_next;
    logic               phase_reg,     phase_next;

    op_t                op;
    logic [LEVEL_W-1:0] sat_level;
    logic               wrote;
    logic [DUTY_W+LEVEL_W-1:0] duty_full;

    assign op        = op_t'(cmd.opcode);
    assign sat_level = (cmd.value > VALUE_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                         : cmd.value[LEVEL_W-1:0];

    always_comb
    begin
        level_next     = level_reg;
        blink_lvl_next = blink_lvl_reg;
        off_dl_next    = off_dl_reg;
        blink_dl_next  = blink_dl_reg;
        period_next    = period_reg;
        phase_next     = phase_reg;
        wrote          = 1'b0;
        unique case (op)
            OP_SET_LEVEL:
            begin
                level_next = sat_level;
                wrote      = 1'b1;
                if (sat_level != '0)
                begin
                    blink_lvl_next = sat_level;
                    off_dl_next    = cmd.now_ms + max_on_reg;
                end
            end
            OP_SET_BLINK:
            begin
                phase_next = 1'b0;
                if (cmd.value == '0)
                begin
                    period_next    = '0;
                    blink_dl_next  = '0;
                    blink_lvl_next = '0;
                end
                else
                begin
                    period_next   = cmd.value;
                    blink_dl_next = cmd.now_ms + cmd.value;
                    if (level_reg != '0)
                    begin
                        blink_lvl_next = level_reg;
                    end
                end
            end
            OP_TICK:
            begin
                if (blink_dl_reg != '0 || off_dl_reg != '0)
                begin
                    // safety timeout wins over blinking
                    if (cmd.now_ms >= off_dl_reg)
                    begin
                        off_dl_next = '0;
                        level_next  = '0;
                        wrote       = 1'b1;
                    end
                    else if (blink_dl_reg != '0 && cmd.now_ms >= blink_dl_reg)
                    begin
                        phase_next    = !phase_reg;
                        level_next    = phase_reg ? blink_lvl_reg : '0;
                        wrote         = 1'b1;
                        blink_dl_next = cmd.now_ms + period_reg;
                    end
                end
            end
            default:
            begin
                wrote = 1'b0;
            end
        endcase
    end

    assign duty_full = (DUTY_W+LEVEL_W)'(DUTY_STEP) * (DUTY_W+LEVEL_W)'(level_next);

    always_comb
    begin
        result.duty         = duty_full[DUTY_W-1:0];
        result.duty_written = wrote;
        result.laser_on     = (level_next != '0)
                              || (blink_lvl_next != '0 && off_dl_next != '0);
        result.level_now    = level_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_on_reg    <= '0;
            level_reg     <= '0;
            blink_lvl_reg <= '0;
            off_dl_reg    <= '0;
            blink_dl_reg  <= '0;
            period_reg    <= '0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_on_reg <= cfg_data;
            end
            if (fire)
            begin
                level_reg     <= level_next;
                blink_lvl_reg <= blink_lvl_next;
                off_dl_reg    <= off_dl_next;
                blink_dl_reg  <= blink_dl_next;
                period_reg    <= period_next;
                phase_reg     <= phase_next;
            end
        end
    end

endmodule

### design/lbtc_out_stage.sv
// ----------------------------------------------------------------------------
// lbtc_out_stage
// result register toward the consumer
// ----------------------------------------------------------------------------
module lbtc_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    output logic              res_ready,
    input  lbtc_pkg::result_t res,
    output logic              out_valid,
    input  logic              out_ready,
    output lbtc_pkg::result_t out_res
);
    import lbtc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign res_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_ready)
        begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

### design/laser_blink_timeout_controller.sv
// ----------------------------------------------------------------------------
// laser_blink_timeout_controller
// laser intensity, blink and safety off timeout controller
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------
//  input    | in_valid / in_ready  | opcode, value, now_ms
//  output   | out_valid / out_ready| duty, duty_written, laser_on, level_now
//  config   | cfg_we               | cfg_data (max on time in ms)
//
//  one item per cycle sustained while out_ready stays high; a command
//  passes the input register, then the state update into the result
//  register, before its result is offered as out_valid
//  state is updated when a command leaves the input register, so the
//  following command already sees it
//  reset clears all state and the max on time to zero, no clearing pass
//  a stalled output holds the result register; the input register keeps
//  taking a transfer whenever it drains in the same cycle
// ----------------------------------------------------------------------------
module laser_blink_timeout_controller (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_we,
    input  logic [lbtc_pkg::TIME_W-1:0]        cfg_data,
    // command input
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [lbtc_pkg::OP_W-1:0]          opcode,
    input  logic [lbtc_pkg::VALUE_W-1:0]       value,
    input  logic [lbtc_pkg::TIME_W-1:0]        now_ms,
    // result output
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [lbtc_pkg::DUTY_W-1:0]        duty,
    output logic                               duty_written,
    output logic                               laser_on,
    output logic [lbtc_pkg::LEVEL_W-1:0]       level_now
);
    import lbtc_pkg::*;

    cmd_t    in_cmd;
    cmd_t    cmd;
    logic    cmd_valid;
    logic    res_ready;
    logic    fire;
    result_t res;
    result_t out_res;

    assign in_cmd.opcode = opcode;
    assign in_cmd.value  = value;
    assign in_cmd.now_ms = now_ms;

    // a command is executed when the result register can take its result
    assign fire = cmd_valid && res_ready;

    lbtc_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_cmd    (in_cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (fire),
        .cmd       (cmd)
    );

    lbtc_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .fire     (fire),
        .cmd      (cmd),
        .result   (res)
    );

    lbtc_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (cmd_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    // result fields to ports
    assign duty         = out_res.duty;
    assign duty_written = out_res.duty_written;
    assign laser_on     = out_res.laser_on;
    assign level_now    = out_res.level_now;

endmodule
